// ===== design/gmtd_pkg.sv =====
package gmtd_pkg;

  localparam int unsigned STALL_LIMIT = 20;
  localparam int unsigned CNT_W       = 6;
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  localparam int unsigned FORCE_W  = 24;
  localparam int unsigned THR_W    = 23;
  localparam int unsigned STEP_W   = 24;
  localparam int unsigned POS_W    = 32;
  localparam int unsigned SQ_W     = 2 * FORCE_W - 1;
  localparam int unsigned SUM_W    = SQ_W + 1;
  localparam int unsigned THR_SQ_W = 2 * THR_W;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_FORCE_THR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TORQUE_THR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_X     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_Y     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_Z     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_START_X    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_START_Z    = 3'd7;

  localparam logic [THR_W-1:0] FORCE_THR_RST  = 23'd4096;
  localparam logic [THR_W-1:0] TORQUE_THR_RST = 23'd1638;
  localparam logic [POS_W-1:0] START_X_RST    = 32'd163840;
  localparam logic [POS_W-1:0] START_Y_RST    = 32'd1458176;
  localparam logic [POS_W-1:0] START_Z_RST    = 32'd1638400;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_MOVING  = 2'd0,
    ST_TOUCHED = 2'd1,
    ST_STALLED = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [FORCE_W-1:0] force_x;
    logic signed [FORCE_W-1:0] force_y;
    logic signed [FORCE_W-1:0] force_z;
    logic signed [FORCE_W-1:0] torque_x;
    logic signed [FORCE_W-1:0] torque_y;
    logic signed [FORCE_W-1:0] torque_z;
  } in_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] command_x;
    logic signed [POS_W-1:0] command_y;
    logic signed [POS_W-1:0] command_z;
    logic [1:0]              status;
  } out_item_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  // A classified request as it waits between the front and back parts.
  typedef struct packed {
    logic                         touched;
    logic [2:0][FORCE_W-1:0]      force_val;
  } queue_entry_t;

  typedef struct packed {
    logic [2:0][SQ_W-1:0]    sq_force;
    logic [2:0][SQ_W-1:0]    sq_torque;
    logic [2:0][FORCE_W-1:0] force_val;
  } square_stage_t;

endpackage

// ===== design/gmtd_front.sv =====
module gmtd_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  gmtd_pkg::cfg_wr_t       cfg,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  gmtd_pkg::in_item_t      in_data,
  output logic                    push_valid,
  input  logic                    push_ready,
  output gmtd_pkg::queue_entry_t  push_data
);

  logic [gmtd_pkg::THR_W-1:0]    force_thr_r;
  logic [gmtd_pkg::THR_W-1:0]    torque_thr_r;
  logic [gmtd_pkg::THR_SQ_W-1:0] force_thr_sq_r;
  logic [gmtd_pkg::THR_SQ_W-1:0] torque_thr_sq_r;
  logic                          stg_valid_r;
  logic                          stg_valid_nxt;
  gmtd_pkg::square_stage_t       stg_r;
  gmtd_pkg::square_stage_t       stg_nxt;
  logic                          load;
  logic                          push;
  logic [gmtd_pkg::SUM_W-1:0]    force_sum;
  logic [gmtd_pkg::SUM_W-1:0]    torque_sum;

  function automatic logic [gmtd_pkg::SQ_W-1:0] square(
    input logic signed [gmtd_pkg::FORCE_W-1:0] a
  );
    logic signed [2*gmtd_pkg::FORCE_W-1:0] p;
    p = a * a;
    return p[gmtd_pkg::SQ_W-1:0];
  endfunction

  assign push       = stg_valid_r && push_ready;
  assign in_stall   = stg_valid_r && !push_ready;
  assign load       = in_valid && !in_stall;
  assign push_valid = stg_valid_r;

  always_comb begin
    stg_nxt.sq_force[0]  = square(in_data.force_x);
    stg_nxt.sq_force[1]  = square(in_data.force_y);
    stg_nxt.sq_force[2]  = square(in_data.force_z);
    stg_nxt.sq_torque[0] = square(in_data.torque_x);
    stg_nxt.sq_torque[1] = square(in_data.torque_y);
    stg_nxt.sq_torque[2] = square(in_data.torque_z);
    stg_nxt.force_val[0] = in_data.force_x;
    stg_nxt.force_val[1] = in_data.force_y;
    stg_nxt.force_val[2] = in_data.force_z;
    if (load) begin
      stg_valid_nxt = 1'b1;
    end else if (push) begin
      stg_valid_nxt = 1'b0;
    end else begin
      stg_valid_nxt = stg_valid_r;
    end
  end

  always_comb begin
    force_sum = {1'b0, stg_r.sq_force[0]} + {1'b0, stg_r.sq_force[1]}
              + {1'b0, stg_r.sq_force[2]};
    torque_sum = {1'b0, stg_r.sq_torque[0]} + {1'b0, stg_r.sq_torque[1]}
               + {1'b0, stg_r.sq_torque[2]};
    push_data.touched =
      (force_sum > {{(gmtd_pkg::SUM_W - gmtd_pkg::THR_SQ_W){1'b0}}, force_thr_sq_r}) ||
      (torque_sum > {{(gmtd_pkg::SUM_W - gmtd_pkg::THR_SQ_W){1'b0}}, torque_thr_sq_r});
    push_data.force_val = stg_r.force_val;
  end

  // The squared thresholds are registered and follow the threshold registers in the next cycle.
  always_ff @(posedge clk) begin
    force_thr_sq_r  <= force_thr_r * force_thr_r;
    torque_thr_sq_r <= torque_thr_r * torque_thr_r;
    if (load) begin
      stg_r <= stg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      force_thr_r  <= gmtd_pkg::FORCE_THR_RST;
      torque_thr_r <= gmtd_pkg::TORQUE_THR_RST;
      stg_valid_r  <= 1'b0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
      if (cfg.we && cfg.idx == gmtd_pkg::REG_FORCE_THR) begin
        force_thr_r <= cfg.data[gmtd_pkg::THR_W-1:0];
      end
      if (cfg.we && cfg.idx == gmtd_pkg::REG_TORQUE_THR) begin
        torque_thr_r <= cfg.data[gmtd_pkg::THR_W-1:0];
      end
    end
  end

endmodule

// ===== design/gmtd_queue.sv =====
module gmtd_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push_valid,
  output logic                    push_ready,
  input  gmtd_pkg::queue_entry_t  push_data,
  output logic                    pop_valid,
  input  logic                    pop_ready,
  output gmtd_pkg::queue_entry_t  pop_data
);

  gmtd_pkg::queue_entry_t            mem [gmtd_pkg::QUEUE_DEPTH];
  logic [gmtd_pkg::QPTR_W-1:0]       wr_ptr_r;
  logic [gmtd_pkg::QPTR_W-1:0]       rd_ptr_r;
  logic [gmtd_pkg::QCNT_W-1:0]       count_r;
  logic                              push;
  logic                              pop;

  assign push_ready = count_r != gmtd_pkg::QCNT_W'(gmtd_pkg::QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = mem[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + gmtd_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + gmtd_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + gmtd_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - gmtd_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

// ===== design/gmtd_back.sv =====
module gmtd_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  gmtd_pkg::cfg_wr_t       cfg,
  input  logic                    pop_valid,
  output logic                    pop_ready,
  input  gmtd_pkg::queue_entry_t  pop_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output gmtd_pkg::out_item_t     out_data
);

  logic signed [gmtd_pkg::STEP_W-1:0] step_r [3];
  logic [2:0][gmtd_pkg::POS_W-1:0]    pos_r;
  logic [2:0][gmtd_pkg::POS_W-1:0]    pos_nxt;
  logic [2:0][gmtd_pkg::FORCE_W-1:0]  prev_r;
  logic [2:0][gmtd_pkg::FORCE_W-1:0]  prev_nxt;
  logic [gmtd_pkg::CNT_W-1:0]         cnt_r;
  logic [gmtd_pkg::CNT_W-1:0]         cnt_nxt;
  gmtd_pkg::status_t                  stop_r;
  gmtd_pkg::status_t                  stop_nxt;
  logic                               out_valid_r;
  gmtd_pkg::out_item_t                out_r;
  gmtd_pkg::out_item_t                out_nxt;
  logic                               pop;
  logic                               same;

  assign pop_ready = !out_valid_r || !out_stall;
  assign pop       = pop_valid && pop_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign same      = pop_data.force_val == prev_r;

  always_comb begin
    pos_nxt  = pos_r;
    prev_nxt = prev_r;
    cnt_nxt  = cnt_r;
    stop_nxt = stop_r;
    if (stop_r == gmtd_pkg::ST_MOVING) begin
      if (pop_data.touched) begin
        stop_nxt = gmtd_pkg::ST_TOUCHED;
      end else begin
        if (!same) begin
          cnt_nxt = '0;
        end else if (cnt_r != gmtd_pkg::COUNT_MAX) begin
          cnt_nxt = cnt_r + gmtd_pkg::CNT_W'(1);
        end
        if (cnt_nxt > gmtd_pkg::CNT_W'(gmtd_pkg::STALL_LIMIT)) begin
          stop_nxt = gmtd_pkg::ST_STALLED;
        end else begin
          prev_nxt = pop_data.force_val;
          for (int i = 0; i < 3; i++) begin
            pos_nxt[i] = pos_r[i] + {{(gmtd_pkg::POS_W - gmtd_pkg::STEP_W){step_r[i][gmtd_pkg::STEP_W-1]}},
                                     step_r[i]};
          end
        end
      end
    end
    out_nxt.command_x = pos_nxt[0];
    out_nxt.command_y = pos_nxt[1];
    out_nxt.command_z = pos_nxt[2];
    out_nxt.status    = stop_nxt;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r[0]   <= '0;
      step_r[1]   <= '0;
      step_r[2]   <= '0;
      pos_r[0]    <= gmtd_pkg::START_X_RST;
      pos_r[1]    <= gmtd_pkg::START_Y_RST;
      pos_r[2]    <= gmtd_pkg::START_Z_RST;
      prev_r      <= '0;
      cnt_r       <= '0;
      stop_r      <= gmtd_pkg::ST_MOVING;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        out_valid_r <= 1'b1;
        pos_r       <= pos_nxt;
        prev_r      <= prev_nxt;
        cnt_r       <= cnt_nxt;
        stop_r      <= stop_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      // A start write also moves the commanded position to the new start.
      if (cfg.we) begin
        unique case (cfg.idx)
          gmtd_pkg::REG_STEP_X:  step_r[0] <= cfg.data[gmtd_pkg::STEP_W-1:0];
          gmtd_pkg::REG_STEP_Y:  step_r[1] <= cfg.data[gmtd_pkg::STEP_W-1:0];
          gmtd_pkg::REG_STEP_Z:  step_r[2] <= cfg.data[gmtd_pkg::STEP_W-1:0];
          gmtd_pkg::REG_START_X: pos_r[0]  <= cfg.data[gmtd_pkg::POS_W-1:0];
          gmtd_pkg::REG_START_Y: pos_r[1]  <= cfg.data[gmtd_pkg::POS_W-1:0];
          gmtd_pkg::REG_START_Z: pos_r[2]  <= cfg.data[gmtd_pkg::POS_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== design/guarded_move_touch_detector_core.sv =====
// Path: an accepted request passes the square stage, the queue and the output
// register in that order before its result is shown.
// Throughput: one request per cycle while neither side stalls.
// Reset: synchronous, active low; thresholds, steps and positions return to their
// default values, the stop status to moving and all queues empty. No clearing pass.
module guarded_move_touch_detector_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  gmtd_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output gmtd_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [gmtd_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [gmtd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  gmtd_pkg::cfg_wr_t      cfg;
  logic                   push_valid;
  logic                   push_ready;
  gmtd_pkg::queue_entry_t push_data;
  logic                   pop_valid;
  logic                   pop_ready;
  gmtd_pkg::queue_entry_t pop_data;

  assign cfg.we   = cfg_we;
  assign cfg.idx  = cfg_idx;
  assign cfg.data = cfg_data;

  gmtd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  gmtd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  gmtd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== design/gmtd_checker.sv =====
module gmtd_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input gmtd_pkg::out_item_t             out_data
);

  logic       in_acc;
  logic       out_acc;
  logic [3:0] pending_r;
  logic       seen_stop_r;
  logic [1:0] stop_code_r;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r   <= '0;
      seen_stop_r <= 1'b0;
      stop_code_r <= gmtd_pkg::ST_MOVING;
    end else begin
      pending_r <= pending_r + 4'(in_acc) - 4'(out_acc);
      if (out_acc && out_data.status != gmtd_pkg::ST_MOVING && !seen_stop_r) begin
        seen_stop_r <= 1'b1;
        stop_code_r <= out_data.status;
      end
    end
  end

  // A result is never shown without a request that is still owed one.
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 4'd0)
    else $error("result shown with no request outstanding");

  // Once a stop has been delivered, every later result carries the same status.
  a_stop_latched: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_stop_r |-> out_data.status == stop_code_r)
    else $error("stop status not latched");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status != 2'd3)
    else $error("undefined status code");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind guarded_move_touch_detector_core gmtd_checker u_gmtd_checker (.*);

// ===== dv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gmtd_pkg::*;

  localparam logic [THR_W-1:0] THR_MAX = '1;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    in_item_t              smp;
    bit                    known;
    out_item_t             want;
  } step_row_t;

  logic                  clk      = 1'b0;
  logic                  rst_n    = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data  = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Tracked copy of the block's registers and state.
  logic [THR_W-1:0]   cur_force_thr;
  logic [THR_W-1:0]   cur_torque_thr;
  logic [STEP_W-1:0]  cur_step [3];
  logic [POS_W-1:0]   cur_pos [3];
  logic [FORCE_W-1:0] last_force [3];
  logic [CNT_W-1:0]   same_run;
  status_t            stop_state;

  out_item_t expected_cmds [$];
  int        mismatches   = 0;
  int        tx_idle_pct  = 0;
  int        rx_stall_pct = 0;
  int        hold_req     = 0;
  int        hold_left    = 0;
  int        burst_left   = 0;

  guarded_move_touch_detector_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic longint energy(logic signed [FORCE_W-1:0] a, b, c);
    longint sa, sb, sc;
    sa = a;
    sb = b;
    sc = c;
    return sa * sa + sb * sb + sc * sc;
  endfunction

  function automatic bit force_trips(in_item_t s);
    return energy(s.force_x, s.force_y, s.force_z) >
           longint'(cur_force_thr) * longint'(cur_force_thr);
  endfunction

  function automatic bit torque_trips(in_item_t s);
    return energy(s.torque_x, s.torque_y, s.torque_z) >
           longint'(cur_torque_thr) * longint'(cur_torque_thr);
  endfunction

  function automatic out_item_t predict_tick(in_item_t s);
    out_item_t r;
    bit        same;
    if (stop_state == ST_MOVING) begin
      if (force_trips(s) || torque_trips(s)) begin
        stop_state = ST_TOUCHED;
      end else begin
        same = (s.force_x == last_force[0]) && (s.force_y == last_force[1]) &&
               (s.force_z == last_force[2]);
        if (!same) begin
          same_run = '0;
        end else if (same_run != COUNT_MAX) begin
          same_run = same_run + 1'b1;
        end
        if (same_run > STALL_LIMIT) begin
          stop_state = ST_STALLED;
        end else begin
          last_force[0] = s.force_x;
          last_force[1] = s.force_y;
          last_force[2] = s.force_z;
          for (int i = 0; i < 3; i++) begin
            cur_pos[i] = cur_pos[i] + {{(POS_W-STEP_W){cur_step[i][STEP_W-1]}}, cur_step[i]};
          end
        end
      end
    end
    r.command_x = cur_pos[0];
    r.command_y = cur_pos[1];
    r.command_z = cur_pos[2];
    r.status    = stop_state;
    return r;
  endfunction

  // Random sample that keeps the move going: forces and torques are halved until
  // they stay within the thresholds, and runs of repeated forces end short of a stall.
  function automatic in_item_t draw_sample();
    in_item_t s;
    int       fs, ts;
    fs = $urandom_range(1) ? 0 : $urandom_range(23);
    ts = $urandom_range(1) ? 0 : $urandom_range(23);
    s.force_x  = 24'($urandom());
    s.force_y  = 24'($urandom());
    s.force_z  = 24'($urandom());
    s.torque_x = 24'($urandom());
    s.torque_y = 24'($urandom());
    s.torque_z = 24'($urandom());
    s.torque_x = s.torque_x >>> ts;
    s.torque_y = s.torque_y >>> ts;
    s.torque_z = s.torque_z >>> ts;
    if (burst_left > 0 && same_run < STALL_LIMIT) begin
      burst_left--;
      s.force_x = last_force[0];
      s.force_y = last_force[1];
      s.force_z = last_force[2];
    end else begin
      burst_left = ($urandom_range(99) < 15) ? $urandom_range(20, 1) : 0;
      s.force_x = s.force_x >>> fs;
      s.force_y = s.force_y >>> fs;
      s.force_z = s.force_z >>> fs;
    end
    while (force_trips(s)) begin
      s.force_x = s.force_x / 2;
      s.force_y = s.force_y / 2;
      s.force_z = s.force_z / 2;
    end
    while (torque_trips(s)) begin
      s.torque_x = s.torque_x / 2;
      s.torque_y = s.torque_y / 2;
      s.torque_z = s.torque_z / 2;
    end
    if (s.force_x == last_force[0] && s.force_y == last_force[1] &&
        s.force_z == last_force[2] && same_run >= STALL_LIMIT) begin
      if (s.force_x == 0 && s.force_y == 0 && s.force_z == 0) begin
        s.force_x = 1;
      end else begin
        s.force_x = 0;
        s.force_y = 0;
        s.force_z = 0;
      end
    end
    return s;
  endfunction

  function automatic logic [31:0] pick_step();
    case ($urandom_range(9))
      0:       return 32'h007F_FFFF;
      1:       return 32'hFF80_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_start();
    case ($urandom_range(4))
      0:       return 32'h7FFF_FFFF - $urandom_range(4095);
      1:       return 32'h8000_0000 + $urandom_range(4095);
      default: return $urandom();
    endcase
  endfunction

  function automatic step_row_t sample_row(int fx, fy, fz, tx, ty, tz);
    step_row_t r;
    r.kind         = ROW_SAMPLE;
    r.idx          = '0;
    r.data         = '0;
    r.known        = 1'b0;
    r.want         = '0;
    r.smp.force_x  = fx[FORCE_W-1:0];
    r.smp.force_y  = fy[FORCE_W-1:0];
    r.smp.force_z  = fz[FORCE_W-1:0];
    r.smp.torque_x = tx[FORCE_W-1:0];
    r.smp.torque_y = ty[FORCE_W-1:0];
    r.smp.torque_z = tz[FORCE_W-1:0];
    return r;
  endfunction

  function automatic step_row_t write_row(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] data);
    step_row_t r;
    r.kind  = ROW_WRITE;
    r.idx   = idx;
    r.data  = data;
    r.smp   = '0;
    r.known = 1'b0;
    r.want  = '0;
    return r;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_idx  <= idx;
    cfg_data <= data;
    cfg_we   <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_FORCE_THR:  cur_force_thr  = data[THR_W-1:0];
      REG_TORQUE_THR: cur_torque_thr = data[THR_W-1:0];
      REG_STEP_X:     cur_step[0]    = data[STEP_W-1:0];
      REG_STEP_Y:     cur_step[1]    = data[STEP_W-1:0];
      REG_STEP_Z:     cur_step[2]    = data[STEP_W-1:0];
      REG_START_X:    cur_pos[0]     = data;
      REG_START_Y:    cur_pos[1]     = data;
      REG_START_Z:    cur_pos[2]     = data;
      default: ;
    endcase
  endtask

  // Offers one request and records its expected command once it is taken.
  task automatic offer(input in_item_t smp, input bit known, input out_item_t want);
    out_item_t model_out;
    if (cfg_we) cfg_we <= 1'b0;
    while ($urandom_range(99) < tx_idle_pct) begin
      if (in_valid) in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data  <= smp;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    model_out = predict_tick(smp);
    expected_cmds.push_back(known ? want : model_out);
  endtask

  task automatic wait_idle();
    if (in_valid) in_valid <= 1'b0;
    do @(posedge clk); while (expected_cmds.size() != 0);
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %h actual %h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    out_item_t head;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_cmds.size() == 0) begin
        mismatches++;
        $display("%0t: result with no request pending, expected none actual %h",
                 $time, out_data);
      end else begin
        head = expected_cmds.pop_front();
        check_field("command_x", head.command_x, out_data.command_x);
        check_field("command_y", head.command_y, out_data.command_y);
        check_field("command_z", head.command_z, out_data.command_z);
        check_field("status", 32'(head.status), 32'(out_data.status));
      end
    end
  end

  // The receiver stalls at random, or for a requested stretch counted here.
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  initial begin
    step_row_t             script [$];
    step_row_t             r;
    out_item_t             home;
    in_item_t              smp;
    logic [CFG_DATA_W-1:0] thr;
    int                    tx_mode [4];
    int                    rx_mode [4];
    int                    variant;

    cur_force_thr  = FORCE_THR_RST;
    cur_torque_thr = TORQUE_THR_RST;
    cur_pos[0]     = START_X_RST;
    cur_pos[1]     = START_Y_RST;
    cur_pos[2]     = START_Z_RST;
    for (int i = 0; i < 3; i++) begin
      cur_step[i]   = '0;
      last_force[i] = '0;
    end
    same_run   = '0;
    stop_state = ST_MOVING;

    home = '{command_x: START_X_RST, command_y: START_Y_RST, command_z: START_Z_RST,
             status: ST_MOVING};

    // With the reset settings the steps are zero, so the start position holds;
    // values sitting exactly on a threshold do not count as a touch.
    r = sample_row(0, 0, 0, 0, 0, 0);
    r.known = 1'b1;
    r.want  = home;
    script.push_back(r);
    r = sample_row(4096, 0, 0, 0, 0, 1638);
    r.known = 1'b1;
    r.want  = home;
    script.push_back(r);
    r = sample_row(-4096, 0, 0, 0, -1638, 0);
    r.known = 1'b1;
    r.want  = home;
    script.push_back(r);
    script.push_back(write_row(REG_FORCE_THR, 32'hFFFF_FFFF));
    script.push_back(write_row(REG_TORQUE_THR, 32'(THR_MAX)));
    script.push_back(write_row(REG_STEP_X, 32'h007F_FFFF));
    script.push_back(write_row(REG_STEP_Y, 32'h0080_0000));
    script.push_back(write_row(REG_STEP_Z, 32'h0000_0001));
    script.push_back(write_row(REG_START_X, 32'h7FFF_FFFF));
    script.push_back(write_row(REG_START_Y, 32'h8000_0000));
    script.push_back(write_row(REG_START_Z, 32'h0000_0000));
    // Largest positive and negative magnitudes that still sit on the threshold;
    // the positions wrap past the ends of their range.
    script.push_back(sample_row(8388607, 0, 0, 0, 0, 0));
    script.push_back(sample_row(0, 8388607, 0, 8388607, 0, 0));
    script.push_back(sample_row(0, 0, 8388607, 0, 8388607, 0));
    script.push_back(sample_row(-4194305, -1, 1, 0, 0, 8388607));
    script.push_back(sample_row(-1, -1, -1, -1, -1, -1));
    script.push_back(sample_row(-8388607, 0, 0, 0, 0, -8388607));
    script.push_back(write_row(REG_FORCE_THR, 32'h0));
    script.push_back(write_row(REG_TORQUE_THR, 32'h0));
    script.push_back(sample_row(0, 0, 0, 0, 0, 0));
    script.push_back(sample_row(0, 0, 0, 0, 0, 0));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[k]) begin
      if (script[k].kind == ROW_WRITE) begin
        if (k == 0 || script[k-1].kind != ROW_WRITE) wait_idle();
        write_reg(script[k].idx, script[k].data);
      end else begin
        offer(script[k].smp, script[k].known, script[k].want);
      end
    end

    tx_mode = '{0, 49, 0, 24};
    rx_mode = '{0, 0, 49, 24};
    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      tx_idle_pct  = tx_mode[ph];
      rx_stall_pct = rx_mode[ph];
      thr = (ph % 2 == 0) ? 32'(THR_MAX) :
            ($urandom_range(1) ? $urandom_range(5000, 1) : $urandom_range(8388607, 1));
      write_reg(REG_FORCE_THR, thr | ($urandom() & 32'hFF80_0000));
      thr = (ph % 2 == 0) ? 32'(THR_MAX) :
            ($urandom_range(1) ? $urandom_range(5000, 1) : $urandom_range(8388607, 1));
      write_reg(REG_TORQUE_THR, thr | ($urandom() & 32'hFF80_0000));
      write_reg(REG_STEP_X, pick_step());
      write_reg(REG_STEP_Y, pick_step());
      write_reg(REG_STEP_Z, pick_step());
      write_reg(REG_START_X, pick_start());
      write_reg(REG_START_Y, pick_start());
      write_reg(REG_START_Z, pick_start());
      burst_left = 0;
      for (int n = 0; n < 385; n++) begin
        // Hold the receiver off long enough for the block to back up its input.
        if (ph == 0 && n == 100) hold_req = 80;
        if (ph == 1 && n == 190) wait_idle();
        offer(draw_sample(), 1'b0, '0);
      end
    end

    // Bring the move to a stop: a stalled sensor, a touch that wins over a stall
    // on the same tick, or a touch at the most negative force.
    wait_idle();
    tx_idle_pct  = 24;
    rx_stall_pct = 24;
    write_reg(REG_FORCE_THR, 32'(THR_MAX));
    write_reg(REG_TORQUE_THR, 32'(THR_MAX));
    variant = $urandom_range(2);
    smp = '0;
    if (variant == 2) begin
      smp.force_x = 24'h80_0000;
      smp.force_y = 24'h80_0000;
      smp.force_z = 24'h80_0000;
      offer(smp, 1'b0, '0);
    end else begin
      smp.force_x = 24'sd12345;
      smp.force_y = -24'sd6789;
      smp.force_z = 24'sd42;
      for (int n = 0; n < 22; n++) begin
        if (variant == 1 && n == 21) smp.torque_x = 24'h80_0000;
        offer(smp, 1'b0, '0);
      end
    end
    // Once stopped the position and status hold whatever arrives.
    repeat (4) begin
      smp = 144'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
      offer(smp, 1'b0, '0);
    end
    wait_idle();
    write_reg(REG_START_X, $urandom());
    repeat (2) begin
      smp = 144'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
      offer(smp, 1'b0, '0);
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
